@@ sv/bmblc_pkg.sv @@
// shared types and constants of the blind motor button and limit controller
package bmblc_pkg;

   // one input beat: sampled pin levels
   typedef struct packed {
      logic down_level;
      logic up_level;
      logic top_level;
      logic bottom_level;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [1:0] motor_request;
      logic       request_issued;
      logic       top_reached_flag;
      logic       bottom_reached_flag;
   } rsp_type;

   // configuration registers as seen by the control logic
   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [23:0] top_reaction_ticks;
      logic [23:0] bottom_reaction_ticks;
   } cfg_type;

   // register indexes
   localparam logic [1:0] REG_DEBOUNCE        = 2'd0;
   localparam logic [1:0] REG_TOP_REACTION    = 2'd1;
   localparam logic [1:0] REG_BOTTOM_REACTION = 2'd2;

   // register reset values
   localparam logic [15:0] DEBOUNCE_RESET = 16'd20000;
   localparam logic [23:0] REACTION_RESET = 24'd1000000;

   // motor request codes
   localparam logic [1:0] REQ_OFF = 2'd0;
   localparam logic [1:0] REQ_CW  = 2'd1;
   localparam logic [1:0] REQ_ACW = 2'd2;

   // limit sequence phases
   localparam logic [1:0] LIMIT_IDLE     = 2'd0;
   localparam logic [1:0] LIMIT_DEBOUNCE = 2'd1;
   localparam logic [1:0] LIMIT_REACTION = 2'd2;

   // bit positions in the level vector
   localparam int LV_DOWN   = 0;
   localparam int LV_UP     = 1;
   localparam int LV_TOP    = 2;
   localparam int LV_BOTTOM = 3;

endpackage

@@ sv/bmblc_csr.sv @@
// apb configuration registers
module bmblc_csr
   import bmblc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [15:0] debounce_ff;
   logic [23:0] top_reaction_ff;
   logic [23:0] bottom_reaction_ff;
   logic        wr_en;
   logic [1:0]  reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff        <= DEBOUNCE_RESET;
         top_reaction_ff    <= REACTION_RESET;
         bottom_reaction_ff <= REACTION_RESET;
      end else if (wr_en) begin
         if (reg_index == REG_DEBOUNCE) begin
            debounce_ff <= pwdata[15:0];
         end
         if (reg_index == REG_TOP_REACTION) begin
            top_reaction_ff <= pwdata[23:0];
         end
         if (reg_index == REG_BOTTOM_REACTION) begin
            bottom_reaction_ff <= pwdata[23:0];
         end
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE:        prdata = {16'd0, debounce_ff};
         REG_TOP_REACTION:    prdata = {8'd0, top_reaction_ff};
         REG_BOTTOM_REACTION: prdata = {8'd0, bottom_reaction_ff};
         default:             prdata = 32'd0;
      endcase
   end

   assign cfg.debounce_ticks        = debounce_ff;
   assign cfg.top_reaction_ticks    = top_reaction_ff;
   assign cfg.bottom_reaction_ticks = bottom_reaction_ff;

endmodule

@@ sv/bmblc_step.sv @@
// per-tick controller state and next-state logic
module bmblc_step
   import bmblc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type step_req,
   input  cfg_type cfg,
   output rsp_type step_rsp
);

   logic [3:0]  previous_levels_ff, previous_levels_in;
   logic        started_ff, started_in;
   logic        button_watch_armed_ff, button_watch_armed_in;
   logic        limit_watch_armed_ff, limit_watch_armed_in;
   logic        button_busy_ff, button_busy_in;
   logic        button_is_up_ff, button_is_up_in;
   logic [15:0] button_count_ff, button_count_in;
   logic [1:0]  limit_phase_ff, limit_phase_in;
   logic        limit_is_top_ff, limit_is_top_in;
   logic [23:0] limit_count_ff, limit_count_in;
   logic        top_reached_ff, top_reached_in;
   logic        bottom_reached_ff, bottom_reached_in;
   logic [1:0]  last_request_ff, last_request_in;
   logic        issued;
   logic [3:0]  lv;
   logic [3:0]  rise;
   logic        limit_high;
   logic        button_high;

   assign lv = {step_req.bottom_level, step_req.top_level,
                step_req.up_level, step_req.down_level};
   assign rise        = lv & ~previous_levels_ff;
   assign limit_high  = limit_is_top_ff ? lv[LV_TOP] : lv[LV_BOTTOM];
   assign button_high = button_is_up_ff ? lv[LV_UP] : lv[LV_DOWN];

   // next state for one tick: limit timer, button timer, then new edges
   always_comb begin
      previous_levels_in    = previous_levels_ff;
      started_in            = started_ff;
      button_watch_armed_in = button_watch_armed_ff;
      limit_watch_armed_in  = limit_watch_armed_ff;
      button_busy_in        = button_busy_ff;
      button_is_up_in       = button_is_up_ff;
      button_count_in       = button_count_ff;
      limit_phase_in        = limit_phase_ff;
      limit_is_top_in       = limit_is_top_ff;
      limit_count_in        = limit_count_ff;
      top_reached_in        = top_reached_ff;
      bottom_reached_in     = bottom_reached_ff;
      last_request_in       = last_request_ff;
      issued                = 1'b0;

      if (!started_ff) begin
         // first tick only loads levels and limit flags
         started_in         = 1'b1;
         previous_levels_in = lv;
         top_reached_in     = lv[LV_TOP];
         bottom_reached_in  = lv[LV_BOTTOM];
      end else begin
         // limit timer
         if (limit_phase_ff == LIMIT_DEBOUNCE || limit_phase_ff == LIMIT_REACTION) begin
            if (limit_count_ff <= 24'd1) begin
               if (limit_phase_ff == LIMIT_REACTION) begin
                  limit_watch_armed_in  = 1'b1;
                  button_watch_armed_in = 1'b1;
               end
               if (limit_high) begin
                  // switch confirmed or still held: drive away from it
                  if (limit_is_top_ff) begin
                     top_reached_in  = 1'b1;
                     last_request_in = REQ_CW;
                     limit_count_in  = cfg.top_reaction_ticks;
                  end else begin
                     bottom_reached_in = 1'b1;
                     last_request_in   = REQ_ACW;
                     limit_count_in    = cfg.bottom_reaction_ticks;
                  end
                  issued         = 1'b1;
                  limit_phase_in = LIMIT_REACTION;
               end else if (limit_phase_ff == LIMIT_DEBOUNCE) begin
                  // bounce: drop the sequence quietly
                  limit_phase_in        = LIMIT_IDLE;
                  limit_watch_armed_in  = 1'b1;
                  button_watch_armed_in = 1'b1;
               end else begin
                  // released after reaction
                  if (limit_is_top_ff) begin
                     top_reached_in = 1'b0;
                  end else begin
                     bottom_reached_in = 1'b0;
                  end
                  last_request_in = REQ_OFF;
                  issued          = 1'b1;
                  limit_phase_in  = LIMIT_IDLE;
               end
            end else begin
               limit_count_in = limit_count_ff - 24'd1;
            end
         end else begin
            limit_phase_in = LIMIT_IDLE;
         end

         // button timer
         if (button_busy_ff) begin
            if (button_count_ff <= 16'd1) begin
               if (button_high) begin
                  if (button_is_up_ff) begin
                     if (!top_reached_in) begin
                        last_request_in = REQ_ACW;
                        issued          = 1'b1;
                     end
                  end else begin
                     if (!bottom_reached_in) begin
                        last_request_in = REQ_CW;
                        issued          = 1'b1;
                     end
                  end
                  button_count_in = cfg.debounce_ticks;
               end else begin
                  last_request_in       = REQ_OFF;
                  issued                = 1'b1;
                  button_busy_in        = 1'b0;
                  button_watch_armed_in = 1'b1;
               end
            end else begin
               button_count_in = button_count_ff - 16'd1;
            end
         end

         // new rising edges, limits first
         if (limit_watch_armed_in && (rise[LV_TOP] || rise[LV_BOTTOM])) begin
            limit_is_top_in       = rise[LV_TOP];
            limit_watch_armed_in  = 1'b0;
            button_watch_armed_in = 1'b0;
            limit_phase_in        = LIMIT_DEBOUNCE;
            limit_count_in        = {8'd0, cfg.debounce_ticks};
         end else if (button_watch_armed_in && (rise[LV_DOWN] || rise[LV_UP])) begin
            button_is_up_in       = !rise[LV_DOWN];
            button_watch_armed_in = 1'b0;
            button_busy_in        = 1'b1;
            button_count_in       = cfg.debounce_ticks;
         end

         previous_levels_in = lv;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_levels_ff    <= 4'd0;
         started_ff            <= 1'b0;
         button_watch_armed_ff <= 1'b1;
         limit_watch_armed_ff  <= 1'b1;
         button_busy_ff        <= 1'b0;
         button_is_up_ff       <= 1'b0;
         button_count_ff       <= 16'd0;
         limit_phase_ff        <= LIMIT_IDLE;
         limit_is_top_ff       <= 1'b0;
         limit_count_ff        <= 24'd0;
         top_reached_ff        <= 1'b0;
         bottom_reached_ff     <= 1'b0;
         last_request_ff       <= REQ_OFF;
      end else if (step_en) begin
         previous_levels_ff    <= previous_levels_in;
         started_ff            <= started_in;
         button_watch_armed_ff <= button_watch_armed_in;
         limit_watch_armed_ff  <= limit_watch_armed_in;
         button_busy_ff        <= button_busy_in;
         button_is_up_ff       <= button_is_up_in;
         button_count_ff       <= button_count_in;
         limit_phase_ff        <= limit_phase_in;
         limit_is_top_ff       <= limit_is_top_in;
         limit_count_ff        <= limit_count_in;
         top_reached_ff        <= top_reached_in;
         bottom_reached_ff     <= bottom_reached_in;
         last_request_ff       <= last_request_in;
      end
   end

   // result of this tick, taken by the output register
   assign step_rsp.motor_request       = last_request_in;
   assign step_rsp.request_issued      = issued;
   assign step_rsp.top_reached_flag    = top_reached_in;
   assign step_rsp.bottom_reached_flag = bottom_reached_in;

endmodule

@@ sv/bmblc_out_reg.sv @@
// result register between the controller and the result channel
module bmblc_out_reg
   import bmblc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // refill whenever the held beat leaves or none is held
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ sv/blind_motor_button_limit_control_core.sv @@
// top level of the blind motor button and limit controller
//
//   channel  | direction | payload   | handshake
//   ---------+-----------+-----------+------------------------------
//   req      | in        | req_type  | req_valid / req_ready
//   rsp      | out       | rsp_type  | rsp_valid / rsp_ready
//   csr      | in/out    | 32b regs  | apb psel / penable / pready
//
// one tick is taken every clock while req_valid and req_ready are high; its
// result is registered and appears in the next cycle in the result register.
// the only loop is the controller state feeding back into its next-state logic.
// reset is synchronous and defaults state, config registers and result valid.
// a stalled result holds only the input side: req_ready falls while a beat
// waits and rsp_ready is low.
module blind_motor_button_limit_control_core
   import bmblc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type cfg;
   rsp_type step_rsp;
   logic    step_en;

   assign step_en = req_valid && req_ready;

   // configuration registers
   bmblc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // controller state and tick logic
   bmblc_step u_step (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .step_req (req_data),
      .cfg      (cfg),
      .step_rsp (step_rsp)
   );

   // result register
   bmblc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

@@ verif/blind_motor_button_limit_control_core_test.sv @@
// self-checking testbench for the blind motor button and limit controller
`timescale 1ns / 1ps

module blind_motor_button_limit_control_core_test;
   import bmblc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // predicted controller state and register copy
   logic [15:0] cfg_debounce;
   logic [23:0] cfg_top_react;
   logic [23:0] cfg_bottom_react;
   logic [3:0]  prev_lv;
   logic        seen_first;
   logic        btn_armed;
   logic        lim_armed;
   logic        btn_running;
   logic        btn_up;
   logic [15:0] btn_left;
   logic [1:0]  lim_phase;
   logic        lim_top;
   logic [23:0] lim_left;
   logic        top_hit;
   logic        bottom_hit;
   logic [1:0]  drive;

   rsp_type motor_outcomes_due[$];
   rsp_type want_rsp;
   int      errors = 0;
   int      ticks_sent = 0;
   int      outcomes_seen = 0;
   int      requests_seen = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      hold_requests = 0;
   int      holds_served = 0;
   int      hold_left = 0;

   blind_motor_button_limit_control_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still due",
                  cycle_count, motor_outcomes_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // predictor: power-on state
   function automatic void reset_model();
      cfg_debounce     = DEBOUNCE_RESET;
      cfg_top_react    = REACTION_RESET;
      cfg_bottom_react = REACTION_RESET;
      prev_lv     = '0;
      seen_first  = 1'b0;
      btn_armed   = 1'b1;
      lim_armed   = 1'b1;
      btn_running = 1'b0;
      btn_up      = 1'b0;
      btn_left    = '0;
      lim_phase   = LIMIT_IDLE;
      lim_top     = 1'b0;
      lim_left    = '0;
      top_hit     = 1'b0;
      bottom_hit  = 1'b0;
      drive       = REQ_OFF;
   endfunction

   // limit confirmed: drive away from it and run the reaction period
   function automatic void start_reaction();
      if (lim_top) begin
         top_hit = 1'b1;
         drive   = REQ_CW;
      end else begin
         bottom_hit = 1'b1;
         drive      = REQ_ACW;
      end
      lim_phase = LIMIT_REACTION;
      lim_left  = lim_top ? cfg_top_react : cfg_bottom_react;
   endfunction

   // predictor: one tick in, one result out
   function automatic rsp_type tick_outcome(input req_type t);
      logic [3:0] lv;
      logic [3:0] rise;
      logic       issued;
      logic       lvl;
      rsp_type    r;
      lv[LV_DOWN]   = t.down_level;
      lv[LV_UP]     = t.up_level;
      lv[LV_TOP]    = t.top_level;
      lv[LV_BOTTOM] = t.bottom_level;
      issued = 1'b0;
      if (!seen_first) begin
         seen_first = 1'b1;
         prev_lv    = lv;
         top_hit    = lv[LV_TOP];
         bottom_hit = lv[LV_BOTTOM];
      end else begin
         rise = lv & ~prev_lv;
         // limit timer first
         if (lim_phase == LIMIT_DEBOUNCE || lim_phase == LIMIT_REACTION) begin
            if (lim_left <= 24'd1) begin
               lvl = lim_top ? lv[LV_TOP] : lv[LV_BOTTOM];
               if (lim_phase == LIMIT_DEBOUNCE) begin
                  if (lvl) begin
                     start_reaction();
                     issued = 1'b1;
                  end else begin
                     lim_phase = LIMIT_IDLE;
                     lim_armed = 1'b1;
                     btn_armed = 1'b1;
                  end
               end else begin
                  lim_armed = 1'b1;
                  btn_armed = 1'b1;
                  if (lvl) begin
                     start_reaction();
                  end else begin
                     if (lim_top) top_hit = 1'b0;
                     else bottom_hit = 1'b0;
                     drive     = REQ_OFF;
                     lim_phase = LIMIT_IDLE;
                  end
                  issued = 1'b1;
               end
            end else begin
               lim_left--;
            end
         end else begin
            lim_phase = LIMIT_IDLE;
         end
         // then the button timer
         if (btn_running) begin
            if (btn_left <= 16'd1) begin
               lvl = btn_up ? lv[LV_UP] : lv[LV_DOWN];
               if (lvl) begin
                  if (btn_up && !top_hit) begin
                     drive  = REQ_ACW;
                     issued = 1'b1;
                  end else if (!btn_up && !bottom_hit) begin
                     drive  = REQ_CW;
                     issued = 1'b1;
                  end
                  btn_left = cfg_debounce;
               end else begin
                  drive       = REQ_OFF;
                  issued      = 1'b1;
                  btn_running = 1'b0;
                  btn_armed   = 1'b1;
               end
            end else begin
               btn_left--;
            end
         end
         // new edges: limits beat buttons
         if (lim_armed && (rise[LV_TOP] || rise[LV_BOTTOM])) begin
            lim_top   = rise[LV_TOP];
            lim_armed = 1'b0;
            btn_armed = 1'b0;
            lim_phase = LIMIT_DEBOUNCE;
            lim_left  = {8'd0, cfg_debounce};
         end else if (btn_armed && (rise[LV_DOWN] || rise[LV_UP])) begin
            btn_up      = !rise[LV_DOWN];
            btn_armed   = 1'b0;
            btn_running = 1'b1;
            btn_left    = cfg_debounce;
         end
         prev_lv = lv;
      end
      r.motor_request       = drive;
      r.request_issued      = issued;
      r.top_reached_flag    = top_hit;
      r.bottom_reached_flag = bottom_hit;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // result side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // compare every result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (motor_outcomes_due.size() == 0) begin
            $error("result beat with no tick waiting: %p", rsp_data);
            errors++;
         end else begin
            want_rsp = motor_outcomes_due.pop_front();
            check_field("motor_request", want_rsp.motor_request, rsp_data.motor_request);
            check_field("request_issued", want_rsp.request_issued,
                        rsp_data.request_issued);
            check_field("top_reached_flag", want_rsp.top_reached_flag,
                        rsp_data.top_reached_flag);
            check_field("bottom_reached_flag", want_rsp.bottom_reached_flag,
                        rsp_data.bottom_reached_flag);
            outcomes_seen++;
            if (rsp_data.request_issued) requests_seen++;
         end
      end
   end

   // send one tick beat, predicting its result on acceptance
   task automatic send_tick(input req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      motor_outcomes_due.push_back(tick_outcome(t));
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (motor_outcomes_due.size() != 0) @(posedge clock);
   endtask

   // write one register while idle, then read it back
   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      wait_drained();
      repeat (2) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_DEBOUNCE:        cfg_debounce     = value[15:0];
         REG_TOP_REACTION:    cfg_top_react    = value[23:0];
         REG_BOTTOM_REACTION: cfg_bottom_react = value[23:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("prdata", value, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_periods(input int deb, input int top_r, input int bot_r);
      set_register(REG_DEBOUNCE, deb);
      set_register(REG_TOP_REACTION, top_r);
      set_register(REG_BOTTOM_REACTION, bot_r);
   endtask

   // one press/hit sequence with random content, or a burst of noise
   task automatic send_segment();
      int         span;
      int         len;
      logic [3:0] lv;
      span = int'(cfg_debounce) + ((cfg_top_react > cfg_bottom_react) ?
                                   int'(cfg_top_react) : int'(cfg_bottom_react));
      if ($urandom_range(99) < 15) begin
         len = $urandom_range(1, 8);
         repeat (len) send_tick(req_type'($urandom_range(15)));
      end else begin
         lv = 4'b0001 << $urandom_range(3);
         if ($urandom_range(99) < 30) lv = lv | (4'b0001 << $urandom_range(3));
         len = $urandom_range(1, 2 * span + 4);
         repeat (len) begin
            // occasional glitch breaks the sequence
            if ($urandom_range(99) < 8) lv = lv ^ (4'b0001 << $urandom_range(3));
            send_tick(req_type'(lv));
         end
         len = $urandom_range(1, span + 2);
         repeat (len) send_tick(req_type'(4'b0000));
      end
   endtask

   // first tick only loads levels and limit flags
   task automatic test_first_tick();
      send_tick(req_type'(4'b1111));
      send_tick(req_type'(4'b0000));
   endtask

   // hand-picked sequences over the main paths
   task automatic test_directed();
      set_periods(2, 2, 3);
      // held button while its limit is reached, then release
      repeat (4) send_tick(req_type'(4'b1000));
      repeat (2) send_tick(req_type'(4'b0000));
      // limit bounce that ends low
      send_tick(req_type'(4'b0010));
      repeat (2) send_tick(req_type'(4'b0000));
      // top hit, button edge while disarmed, reaction restart, release
      send_tick(req_type'(4'b0010));
      repeat (2) send_tick(req_type'(4'b1010));
      repeat (4) send_tick(req_type'(4'b0010));
      repeat (3) send_tick(req_type'(4'b0000));
      // all edges at once
      repeat (2) send_tick(req_type'(4'b1111));
      repeat (2) send_tick(req_type'(4'b0000));
   endtask

   // zero in a period register counts as one tick
   task automatic test_zero_period();
      set_periods(0, 0, 1);
      while (ticks_sent < 70) send_segment();
   endtask

   // long result stall while ticks keep coming
   task automatic test_backpressure();
      set_periods(1, 2, 2);
      hold_requests++;
      repeat (60) send_tick(req_type'($urandom_range(15)));
   endtask

   // random sequences at small periods, with one full pause midway
   task automatic test_random(input int s_pct, input int r_pct, input int count);
      int target;
      int pause_at;
      bit paused;
      send_idle_pct = s_pct;
      rsp_idle_pct  = r_pct;
      set_periods($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 6));
      target   = ticks_sent + count;
      pause_at = ticks_sent + count / 2;
      paused   = 1'b0;
      while (ticks_sent < target) begin
         send_segment();
         if (!paused && ticks_sent >= pause_at) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   // full-width debounce counter: load it and hold a button well short of expiry
   task automatic test_long_debounce();
      repeat (20) send_tick(req_type'(4'b0000));
      set_register(REG_DEBOUNCE, 32'hFFFF);
      repeat (40) send_tick(req_type'(4'b0100));
      repeat (4) send_tick(req_type'(4'b0000));
   endtask

   // full-width reaction periods; a hit here never times out within the run
   task automatic test_long_reaction();
      set_periods(1, 24'hFFFFFF, 24'hFFFFFF);
      repeat (8) send_tick(req_type'(4'b0010));
      repeat (4) send_tick(req_type'(4'b1001));
      repeat (4) send_tick(req_type'(4'b0000));
   endtask

   initial begin
      reset_model();
      send_idle_pct = 9;
      rsp_idle_pct  = 67;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_first_tick();
      test_directed();
      test_zero_period();
      test_backpressure();
      test_random(9, 67, 300);
      test_random(67, 9, 300);
      test_random(0, 0, 300);
      test_long_debounce();
      test_long_reaction();
      wait_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d ticks, checked %0d result beats, %0d with a fresh request",
               ticks_sent, outcomes_seen, requests_seen);
      $display("periods swept from zero to full width under three stall mixes");
      if (errors == 0 && motor_outcomes_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
